FILE: sv/mzm_pkg.sv
// package: payload types, register codes and the cosine table function
package mzm_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned DRIVE_WIDTH  = 16;
  localparam int unsigned GAIN_WIDTH   = 18;
  localparam int unsigned BIAS_WIDTH   = 16;
  localparam int unsigned COS_WIDTH    = 17;
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = GAIN_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIAS = 2'd1;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_RESET = 18'sd4681;
  localparam logic [BIAS_WIDTH-1:0]        BIAS_RESET = 16'd0;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [DRIVE_WIDTH-1:0]  drive_voltage;
    logic signed [SAMPLE_WIDTH-1:0] field_real;
    logic signed [SAMPLE_WIDTH-1:0] field_imag;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] mod_real;
    logic signed [SAMPLE_WIDTH-1:0] mod_imag;
  } out_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] field_real;
    logic signed [SAMPLE_WIDTH-1:0] field_imag;
  } sample_pair_t;

  // pipeline control between stages
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctrl_t;

  // cos(pi/2 * i / 2^tb) in Q1.15, integer taylor series in Q30
  function automatic logic [COS_WIDTH-1:0] cos_entry(int unsigned tb, int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = (HALF_PI_Q30 * 64'(i) + (64'd1 << (tb - 1))) >> tb;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    term = ((term * x2) >> 30) / 2;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 12;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 30;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 56;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 90;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 132;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 182;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 240;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 << 30)) begin
      sum = 64'sd1 << 30;
    end
    rnd = (64'(sum) + (64'd1 << 14)) >> 15;
    return rnd[COS_WIDTH-1:0];
  endfunction

endpackage

FILE: sv/mzm_phase.sv
// half-phase stages: drive times gain, bias add with wrap, table index and sign
module mzm_phase #(
  parameter int unsigned TABLE_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  mzm_pkg::in_t                             in_data,
  input  logic signed [mzm_pkg::GAIN_WIDTH-1:0]    gain,
  input  logic [mzm_pkg::BIAS_WIDTH-1:0]           bias,
  output mzm_pkg::stage_ctrl_t                     ctrl,
  output logic [TABLE_BITS:0]                      idx,
  output logic                                     neg,
  output mzm_pkg::sample_pair_t                    fields
);

  localparam int unsigned SH = 14 - TABLE_BITS;
  localparam int unsigned PW = mzm_pkg::DRIVE_WIDTH + mzm_pkg::GAIN_WIDTH;
  localparam logic [TABLE_BITS:0] FULL = (TABLE_BITS+1)'(1) << TABLE_BITS;

  logic                           valid_a;
  logic [27:0]                    prod;
  mzm_pkg::sample_pair_t          fields_a;
  logic                           valid_b;

  logic signed [PW-1:0]           prod_full;
  logic [27:0]                    prod_rnd;
  logic [15:0]                    h;
  logic [14:0]                    off_rnd;
  logic [TABLE_BITS:0]            idx_raw;
  logic [TABLE_BITS:0]            idx_next;
  logic                           neg_next;

  assign prod_full = PW'(in_data.drive_voltage) * PW'(gain);

  always_comb begin
    prod_rnd = prod + 28'd2048;
    h        = prod_rnd[27:12] + bias;
    off_rnd  = {1'b0, h[13:0]} + (15'd1 << (SH - 1));
    idx_raw  = off_rnd[14:SH];
    neg_next = (h[15:14] == 2'd1) || (h[15:14] == 2'd2);
    if (h[14]) begin
      idx_next = FULL - idx_raw;
    end else begin
      idx_next = idx_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod                <= prod_full[27:0];
      fields_a.field_real <= in_data.field_real;
      fields_a.field_imag <= in_data.field_imag;
      idx                 <= idx_next;
      neg                 <= neg_next;
      fields              <= fields_a;
    end
  end

  assign ctrl.en    = en;
  assign ctrl.valid = valid_b;

endmodule

FILE: sv/mzm_cos_rom.sv
// quarter-wave cosine table with registered, signed read
module mzm_cos_rom #(
  parameter int unsigned TABLE_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mzm_pkg::stage_ctrl_t                   ctrl_in,
  input  logic [TABLE_BITS:0]                    idx,
  input  logic                                   neg,
  input  mzm_pkg::sample_pair_t                  fields_in,
  output mzm_pkg::stage_ctrl_t                   ctrl_out,
  output logic signed [mzm_pkg::COS_WIDTH-1:0]   cos_val,
  output mzm_pkg::sample_pair_t                  fields_out
);

  localparam int unsigned N = 1 << TABLE_BITS;

  logic [mzm_pkg::COS_WIDTH-1:0]         cos_tab [0:N];
  logic [mzm_pkg::COS_WIDTH-1:0]         entry;
  logic signed [mzm_pkg::COS_WIDTH-1:0]  cos_next;
  logic                                  valid;

  for (genvar i = 0; i <= N; i++) begin : g_tab
    localparam logic [mzm_pkg::COS_WIDTH-1:0] V = mzm_pkg::cos_entry(TABLE_BITS, i);
    assign cos_tab[i] = V;
  end

  always_comb begin
    entry = cos_tab[idx];
    if (neg) begin
      cos_next = -$signed(entry);
    end else begin
      cos_next = $signed(entry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl_in.en) begin
      valid <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.en) begin
      cos_val    <= cos_next;
      fields_out <= fields_in;
    end
  end

  assign ctrl_out.en    = ctrl_in.en;
  assign ctrl_out.valid = valid;

endmodule

FILE: sv/mzm_scale.sv
// field scaling stages: multiply by cosine, round half up, saturate
module mzm_scale (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mzm_pkg::stage_ctrl_t                   ctrl_in,
  input  logic signed [mzm_pkg::COS_WIDTH-1:0]   cos_val,
  input  mzm_pkg::sample_pair_t                  fields,
  output logic                                   out_valid,
  output mzm_pkg::out_t                          out_data
);

  localparam int unsigned SW = mzm_pkg::SAMPLE_WIDTH;
  localparam int unsigned MW = SW + mzm_pkg::COS_WIDTH;
  localparam int unsigned QW = MW - 15;
  localparam logic signed [QW-1:0] QMAX = QW'((1 << (SW - 1)) - 1);
  localparam logic signed [QW-1:0] QMIN = -QW'(1 << (SW - 1));

  logic                  valid_p;
  logic signed [MW-1:0]  prod_re;
  logic signed [MW-1:0]  prod_im;
  mzm_pkg::out_t         out_next;

  function automatic logic signed [SW-1:0] round_sat(logic signed [MW-1:0] p);
    logic signed [MW-1:0] s;
    logic signed [QW-1:0] q;
    s = p + MW'(1 << 14);
    q = QW'(s >>> 15);
    if (q > QMAX) begin
      q = QMAX;
    end else if (q < QMIN) begin
      q = QMIN;
    end
    return q[SW-1:0];
  endfunction

  always_comb begin
    out_next.mod_real = round_sat(prod_re);
    out_next.mod_imag = round_sat(prod_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p   <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctrl_in.en) begin
      valid_p   <= ctrl_in.valid;
      out_valid <= valid_p;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.en) begin
      prod_re  <= MW'(fields.field_real) * MW'(cos_val);
      prod_im  <= MW'(fields.field_imag) * MW'(cos_val);
      out_data <= out_next;
    end
  end

endmodule

FILE: sv/mzm_field_modulator_core.sv
// top level: push-pull field modulator, config registers and pipeline control
// pipeline: five register stages (gain product, phase wrap and index, table read,
//   field product, round/saturate)
// throughput: one sample per cycle; an output stall freezes every stage
// reset: clears all stage valid bits, gain to 4681, bias to 0; cfg_ready stays high
module mzm_field_modulator_core #(
  parameter int unsigned TABLE_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  mzm_pkg::in_t                             in_data,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output mzm_pkg::out_t                            out_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [mzm_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [mzm_pkg::CFG_DATA_WIDTH-1:0]       cfg_data
);

  logic signed [mzm_pkg::GAIN_WIDTH-1:0]  gain;
  logic [mzm_pkg::BIAS_WIDTH-1:0]         bias;
  logic                                   en;

  mzm_pkg::stage_ctrl_t                   ctrl_phase;
  mzm_pkg::stage_ctrl_t                   ctrl_cos;
  logic [TABLE_BITS:0]                    idx;
  logic                                   neg;
  mzm_pkg::sample_pair_t                  fields_phase;
  mzm_pkg::sample_pair_t                  fields_cos;
  logic signed [mzm_pkg::COS_WIDTH-1:0]   cos_val;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= mzm_pkg::GAIN_RESET;
      bias <= mzm_pkg::BIAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mzm_pkg::REG_GAIN: gain <= $signed(cfg_data);
        mzm_pkg::REG_BIAS: bias <= cfg_data[mzm_pkg::BIAS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  mzm_phase #(
    .TABLE_BITS(TABLE_BITS)
  ) u_phase (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .gain     (gain),
    .bias     (bias),
    .ctrl     (ctrl_phase),
    .idx      (idx),
    .neg      (neg),
    .fields   (fields_phase)
  );

  mzm_cos_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_cos_rom (
    .clk        (clk),
    .rst        (rst),
    .ctrl_in    (ctrl_phase),
    .idx        (idx),
    .neg        (neg),
    .fields_in  (fields_phase),
    .ctrl_out   (ctrl_cos),
    .cos_val    (cos_val),
    .fields_out (fields_cos)
  );

  mzm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .ctrl_in   (ctrl_cos),
    .cos_val   (cos_val),
    .fields    (fields_cos),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sv/mzm_checker.sv
// port-level checks for the modulator core, bound to the top level
module mzm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input mzm_pkg::out_t  out_data,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input is held off only by a blocked result
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an input transfer followed by free flow yields a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall
    |=> out_valid)
    else $error("result missing after pipeline latency");

  // config port never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind mzm_field_modulator_core mzm_checker u_mzm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
